// File: hw/rtl/predictive_pixel_diff_decoder_top_assert.svh
// Assertion macros shared by the decoder RTL. They sample on clk and are
// disabled while rst is high, so they rely on those names in the caller.
`ifndef PREDICTIVE_PIXEL_DIFF_DECODER_TOP_ASSERT_SVH
`define PREDICTIVE_PIXEL_DIFF_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PPDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppdd assertion failed");

// Next-cycle implication.
`define PPDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppdd assertion failed");

`endif

// File: hw/rtl/ppdd_pkg.sv
`timescale 1ns / 1ps
package ppdd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Item kinds
  localparam logic [1:0] KIND_RAW  = 2'd0;
  localparam logic [1:0] KIND_CODE = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // Width codes
  localparam logic [1:0] WCODE_1B  = 2'd0;
  localparam logic [1:0] WCODE_2B  = 2'd1;
  localparam logic [1:0] WCODE_4B  = 2'd2;
  localparam logic [1:0] WCODE_BAD = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;

  localparam logic [10:0] ROW_WIDTH_RST = 11'd1024;
  localparam logic [10:0] ROW_COUNT_RST = 11'd768;

  // code_slot value meaning no codes pending
  localparam logic [2:0] SLOT_IDLE = 3'd4;

  localparam logic [7:0] CODE_MASKS [4] = '{8'h03, 8'h0C, 8'h30, 8'hC0};

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] payload;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] pixel;
    logic [19:0] pixel_index;
    logic        last_pixel;
    logic        fault;
  } result_t;

  // Effective row width: clamp to [4, max_w], round down to a multiple of four.
  function automatic int clamp_width(logic [10:0] v, int max_w);
    int w;
    w = int'(v);
    if (w < 4) w = 4;
    if (w > max_w) w = max_w;
    w = w & ~3;
    if (w < 4) w = 4;
    return w;
  endfunction

  // Effective row count: clamp to [2, max_h].
  function automatic int clamp_height(logic [10:0] v, int max_h);
    int h;
    h = int'(v);
    if (h < 2) h = 2;
    if (h > max_h) h = max_h;
    return h;
  endfunction

endpackage

// File: hw/rtl/ppdd_line_store.sv
`timescale 1ns / 1ps
module ppdd_line_store #(
  parameter int DEPTH  = 1025,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/ppdd_core.sv
`timescale 1ns / 1ps
module ppdd_core
  import ppdd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int ADDR_W  = $clog2(MAX_WIDTH + 1),
  localparam int TOTAL_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  item_t              item,
  input  logic [ADDR_W-1:0]  eff_w,
  input  logic [TOTAL_W-1:0] total,
  input  logic               restart,
  output result_t            res
);

  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [CNT_W-1:0]  pixel_counter, pixel_counter_next;
  logic [ADDR_W-1:0] slot, slot_next, slot_inc, rd_addr;
  logic [2:0]        code_slot, code_slot_next;
  logic [3:0]        bytes_taken, bytes_taken_next;
  logic [31:0]       diff_assembly, diff_assembly_next;
  logic [7:0]        code_byte, code_byte_next;
  logic [31:0]       left_pixel, upleft;
  logic [31:0]       up;

  logic [1:0]        expected, wcode;
  logic              raw_phase, kind_ok, pix_fire, complete, at_end;
  logic [3:0]        need, bytes_inc;
  logic [31:0]       new_diff, diff, pix;
  logic [TOTAL_W-1:0] k_inc;
  logic [63:0]       k_ext;

  assign raw_phase = TOTAL_W'(pixel_counter) <= TOTAL_W'(eff_w);
  assign k_inc     = TOTAL_W'(pixel_counter) + TOTAL_W'(1);
  assign at_end    = k_inc == total;
  assign k_ext     = 64'(pixel_counter);

  always_comb begin
    if (raw_phase) begin
      expected = KIND_RAW;
    end else if (code_slot[2]) begin
      expected = KIND_CODE;
    end else begin
      expected = KIND_DATA;
    end
  end
  assign kind_ok = item.kind == expected;

  assign wcode = 2'((code_byte & CODE_MASKS[code_slot[1:0]]) >> {code_slot[1:0], 1'b0});

  always_comb begin
    case (wcode)
      WCODE_1B:  need = 4'd1;
      WCODE_2B:  need = 4'd2;
      WCODE_4B:  need = 4'd4;
      WCODE_BAD: need = 4'd8;
      default:   need = 4'd8;
    endcase
  end

  assign new_diff  = (bytes_taken[3:2] == 2'b00)
                   ? diff_assembly | (32'(item.payload[7:0]) << {bytes_taken[1:0], 3'b000})
                   : diff_assembly;
  assign bytes_inc = bytes_taken + 4'd1;
  assign complete  = bytes_inc == need;

  always_comb begin
    case (wcode)
      WCODE_1B:  diff = {{24{new_diff[7]}}, new_diff[7:0]};
      WCODE_2B:  diff = {{16{new_diff[15]}}, new_diff[15:0]};
      WCODE_4B:  diff = new_diff;
      default:   diff = 32'd0;
    endcase
  end

  always_comb begin
    if (raw_phase) begin
      pix = item.payload;
    end else begin
      pix = diff + left_pixel + up - upleft;
    end
  end

  // A pixel leaves on a raw word or on the byte that completes a difference.
  assign pix_fire = fire && kind_ok &&
                    (raw_phase || (expected == KIND_DATA && complete));

  assign slot_inc = (slot == eff_w) ? '0 : slot + ADDR_W'(1);

  always_comb begin
    pixel_counter_next = pixel_counter;
    slot_next          = slot;
    code_slot_next     = code_slot;
    bytes_taken_next   = bytes_taken;
    diff_assembly_next = diff_assembly;
    code_byte_next     = code_byte;
    if (fire && kind_ok) begin
      if (expected == KIND_CODE) begin
        code_byte_next     = item.payload[7:0];
        code_slot_next     = 3'd0;
        bytes_taken_next   = 4'd0;
        diff_assembly_next = 32'd0;
      end else if (expected == KIND_DATA) begin
        if (complete) begin
          code_slot_next     = code_slot + 3'd1;
          bytes_taken_next   = 4'd0;
          diff_assembly_next = 32'd0;
        end else begin
          bytes_taken_next   = bytes_inc;
          diff_assembly_next = new_diff;
        end
      end
      if (pix_fire) begin
        pixel_counter_next = CNT_W'(k_inc);
        slot_next          = slot_inc;
      end
    end
    if (restart || (pix_fire && at_end)) begin
      pixel_counter_next = '0;
      slot_next          = '0;
      code_slot_next     = SLOT_IDLE;
      bytes_taken_next   = 4'd0;
      diff_assembly_next = 32'd0;
    end
  end

  // Prefetch the upper neighbor of the next pixel.
  assign rd_addr = (slot_next == eff_w) ? '0 : slot_next + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_counter <= '0;
      slot          <= '0;
      code_slot     <= SLOT_IDLE;
      bytes_taken   <= 4'd0;
      diff_assembly <= 32'd0;
      code_byte     <= 8'd0;
      left_pixel    <= 32'd0;
    end else begin
      pixel_counter <= pixel_counter_next;
      slot          <= slot_next;
      code_slot     <= code_slot_next;
      bytes_taken   <= bytes_taken_next;
      diff_assembly <= diff_assembly_next;
      code_byte     <= code_byte_next;
      if (pix_fire) begin
        left_pixel <= pix;
      end
    end
  end

  // Upper-left of the next pixel is the upper neighbor of this one.
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      upleft <= up;
    end
  end

  ppdd_line_store #(
    .DEPTH  (MAX_WIDTH + 1),
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (pix_fire),
    .wr_addr (slot),
    .wr_data (pix),
    .rd_addr (rd_addr),
    .rd_data (up)
  );

  always_comb begin
    res.valid       = fire && (!kind_ok || pix_fire);
    res.pixel       = kind_ok ? pix : 32'd0;
    res.pixel_index = k_ext[19:0];
    res.last_pixel  = kind_ok && at_end;
    res.fault       = !kind_ok;
  end

`include "predictive_pixel_diff_decoder_top_assert.svh"

  `PPDD_ASSERT_NEXT(a_last_restarts, pix_fire && at_end,
                    pixel_counter == '0 && slot == '0 && code_slot == SLOT_IDLE)
  `PPDD_ASSERT_NOW(a_slot_range, 1'b1, slot <= eff_w && code_slot <= SLOT_IDLE)
  `PPDD_ASSERT_NOW(a_bytes_range, !code_slot[2], bytes_taken < need)
  `PPDD_ASSERT_NOW(a_raw_slot, raw_phase, TOTAL_W'(slot) == TOTAL_W'(pixel_counter))

endmodule

// File: hw/rtl/predictive_pixel_diff_decoder_top.sv
`timescale 1ns / 1ps
// Predictive pixel difference decoder.
//
// Input stream (s_*): one request per item. s_tuser is the item kind (raw
// first-row word, width-code byte, data byte), s_tdata the raw word or a
// byte in bits 7..0. The driver sends each width-code byte ahead of its data.
// Output stream (m_*): one request per reconstructed pixel or per sequence
// fault; m_tlast marks the final pixel of the image, m_tuser flags a fault.
// Config channel (cfg_*): writes row_width / row_count; the user must do so only
// while idle (not enforced). Each restarts the image. cfg_ready is always high.
//
// Path: a result passes through the input register, then the decode/predict
// logic into the output register.
// Throughput: one item per cycle while the output is not stalled; the line
// store takes one write and one prefetch read per cycle.
// Reset: synchronous; the image restarts, sizes return to 1024 x 768 and
// both streams go empty. The line store is not cleared.
// Stall: if m_tready is low the result holds; one more item may be taken into
// an empty input register, then s_tready stays low until the output drains.
module predictive_pixel_diff_decoder_top
  import ppdd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] payload
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [31:0] pixel, [51:32] pixel_index, [55:52] zero
  output logic        m_tlast,   // last_pixel
  output logic        m_tuser,   // [0] fault
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int ADDR_W  = $clog2(MAX_WIDTH + 1);
  localparam int TOTAL_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // Effective image size and pixel count.
  logic [ADDR_W-1:0]  eff_w;
  logic [TOTAL_W-1:0] eff_h;
  logic [TOTAL_W-1:0] total;
  logic               cfg_wr, restart;

  // Input register and output register.
  logic    s1_valid;
  item_t   s1_item;
  logic    out_free, advance;
  result_t res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index == REG_ROW_WIDTH || cfg_index == REG_ROW_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= ADDR_W'(clamp_width(ROW_WIDTH_RST, MAX_WIDTH));
      eff_h <= TOTAL_W'(clamp_height(ROW_COUNT_RST, MAX_HEIGHT));
    end else if (cfg_wr) begin
      if (cfg_index == REG_ROW_WIDTH) begin
        eff_w <= ADDR_W'(clamp_width(cfg_data, MAX_WIDTH));
      end else if (cfg_index == REG_ROW_COUNT) begin
        eff_h <= TOTAL_W'(clamp_height(cfg_data, MAX_HEIGHT));
      end
    end
  end

  // Pixel count is registered from the effective sizes, so it lags a size
  // change; an item can reach the core before it settles.
  always_ff @(posedge clk) begin
    total <= TOTAL_W'(eff_w) * eff_h;
  end

  assign out_free = !m_tvalid || m_tready;
  assign advance  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.kind    <= s_tuser;
      s1_item.payload <= s_tdata;
    end
  end

  ppdd_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .item    (s1_item),
    .eff_w   (eff_w),
    .total   (total),
    .restart (restart),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      m_tdata <= {4'd0, res.pixel_index, res.pixel};
      m_tlast <= res.last_pixel;
      m_tuser <= res.fault;
    end
  end

`include "predictive_pixel_diff_decoder_top_assert.svh"

  `PPDD_ASSERT_NOW(a_fault_clean, m_tvalid && m_tuser, m_tdata[31:0] == 32'd0 && !m_tlast)
  `PPDD_ASSERT_NEXT(a_s1_hold, s1_valid && !out_free, s1_valid && $stable(s1_item))
  `PPDD_ASSERT_NOW(a_result_needs_item, res.valid, advance)

endmodule
